// ----- hw/rtl/sswc_pkg.sv -----
// ----------------------------------------------------------------------------
// sswc_pkg: shared types and constants
// Widths, register indexes, op codes and the result type.
// ----------------------------------------------------------------------------
package sswc_pkg;

  localparam int unsigned COORD_WIDTH_DEF     = 32;
  localparam int unsigned FRAC_BITS_DEF       = 16;
  localparam int unsigned GROW_START_STEP_DEF = 10;

  localparam int unsigned RAD_W  = 31;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUTER    = 3'd3;
  localparam logic [IDX_W-1:0] REG_THICK    = 3'd4;
  localparam logic [IDX_W-1:0] REG_CUTOFF   = 3'd5;
  localparam logic [IDX_W-1:0] REG_GROWTH   = 3'd6;
  localparam logic [IDX_W-1:0] REG_INTERIOR = 3'd7;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic                in_shell;
    logic                has_contact;
    logic [RAD_W-1:0]    contact_distance;
    logic signed [31:0]  offset_x;
    logic signed [31:0]  offset_y;
    logic signed [31:0]  offset_z;
    logic signed [31:0]  wall_radius;
    logic                wall_side;
  } result_t;

endpackage

// ----- hw/rtl/sswc_if.sv -----
// ----------------------------------------------------------------------------
// sswc_if: valid/ready channel
// Carries a payload of type T with a source and a sink side.
// ----------------------------------------------------------------------------
interface sswc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sswc_front.sv -----
// ----------------------------------------------------------------------------
// sswc_front: input stage and classifier
// Accepts items, forms the center offset and effective radii, runs ticks,
// and pushes point jobs (or tick marks) into a two-entry queue.
// ----------------------------------------------------------------------------
module sswc_front import sswc_pkg::*; #(
  parameter int unsigned CW  = COORD_WIDTH_DEF,
  parameter int unsigned GSS = GROW_START_STEP_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [CW-1:0] in_z,
  input  logic signed [CW-1:0] cx,
  input  logic signed [CW-1:0] cy,
  input  logic signed [CW-1:0] cz,
  input  logic [RAD_W-1:0]     outer,
  input  logic [RAD_W-1:0]     thick,
  input  logic signed [31:0]   growth,
  output logic                 q_valid,
  input  logic                 q_pop,
  output logic                 q_tick,
  output logic signed [CW:0]   q_dx,
  output logic signed [CW:0]   q_dy,
  output logic signed [CW:0]   q_dz,
  output logic [RAD_W-1:0]     q_rin,
  output logic [RAD_W-1:0]     q_rout
);
  localparam int unsigned SC_W = $clog2(GSS + 2);
  localparam int unsigned EW   = 1 + 3 * (CW + 1) + 2 * RAD_W;

  logic signed [31:0] goff_r, goff_nxt;
  logic [SC_W-1:0]    sc_r, sc_nxt;
  logic [EW-1:0]      qd_r [2];
  logic [1:0]         qv_r, qv_nxt;
  logic               wp_r, rp_r;
  logic               push;
  logic signed [33:0] gsum, ro_s, ri_s;
  logic [RAD_W-1:0]   ro, ri;
  logic [EW-1:0]      ent;

  assign in_ready = ~qv_r[wp_r];
  assign push     = in_valid & in_ready;

  always_comb begin
    ro_s = 34'(signed'({1'b0, outer})) + 34'(goff_r);
    ri_s = ro_s - 34'(signed'({1'b0, thick}));
    ro = ro_s[33] ? '0 : (|ro_s[32:31] ? {RAD_W{1'b1}} : ro_s[RAD_W-1:0]);
    ri = ri_s[33] ? '0 : (|ri_s[32:31] ? {RAD_W{1'b1}} : ri_s[RAD_W-1:0]);
    ent = {in_op, (CW+1)'(in_x) - (CW+1)'(cx), (CW+1)'(in_y) - (CW+1)'(cy),
           (CW+1)'(in_z) - (CW+1)'(cz), ri, ro};
  end

  always_comb begin
    sc_nxt   = sc_r;
    goff_nxt = goff_r;
    gsum     = 34'(goff_r) + 34'(growth);
    if (push && in_op == OP_TICK) begin
      if (sc_r < SC_W'(GSS + 1)) sc_nxt = sc_r + 1'b1;
      if (sc_nxt > SC_W'(GSS)) begin
        if (gsum > 34'sd2147483647) goff_nxt = 32'sh7fffffff;
        else if (gsum < -34'sd2147483648) goff_nxt = 32'sh80000000;
        else goff_nxt = gsum[31:0];
      end
    end
  end

  always_comb begin
    qv_nxt = qv_r;
    if (push) qv_nxt[wp_r] = 1'b1;
    if (q_pop) qv_nxt[rp_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goff_r <= '0;
      sc_r   <= '0;
      qv_r   <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
    end else begin
      goff_r <= goff_nxt;
      sc_r   <= sc_nxt;
      qv_r   <= qv_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) qd_r[wp_r] <= ent;
  end

  assign q_valid = qv_r[rp_r];
  assign {q_tick, q_dx, q_dy, q_dz, q_rin, q_rout} = qd_r[rp_r];

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (qv_r == 2'b11) |-> !in_ready) else $error("accept while queue full");
  a_sc_sat: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= SC_W'(GSS + 1)) else $error("step count past limit");
endmodule

// ----- hw/rtl/sswc_back.sv -----
// ----------------------------------------------------------------------------
// sswc_back: distance and contact engine
// Squares the offsets one axis at a time, runs a bitwise square root one bit
// per cycle, classifies the contact and, on a contact, divides each offset times delta by r serially.
// ----------------------------------------------------------------------------
module sswc_back import sswc_pkg::*; #(
  parameter int unsigned CW = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic                 q_tick,
  input  logic signed [CW:0]   q_dx,
  input  logic signed [CW:0]   q_dy,
  input  logic signed [CW:0]   q_dz,
  input  logic [RAD_W-1:0]     q_rin,
  input  logic [RAD_W-1:0]     q_rout,
  input  logic [RAD_W-1:0]     cutoff,
  input  logic                 interior,
  output logic                 res_valid,
  input  logic                 res_ready,
  output result_t              res
);
  localparam int unsigned SW = 64;                // saturated sum width
  localparam int unsigned QW = 64;                // quotient width
  localparam int unsigned NW = 128;               // dividend width

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_ROOT = 4'd2;
  localparam logic [3:0] S_CLS  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_OUT  = 4'd6;

  logic [3:0]          st_r;
  logic [6:0]          cnt_r;
  logic [1:0]          ax_r;
  logic signed [CW:0]  d_r [3];
  logic [RAD_W-1:0]    rin_r, rout_r;
  logic [SW-1:0]       sum_r, v_r, res_r, bit_r;
  logic [SW-1:0]       sq;
  logic [SW:0]         sadd;
  logic [SW-1:0]       trial;
  logic [CW:0]         amag;
  logic [31:0]         delta_r;
  logic                dneg_r;
  logic [NW-1:0]       num_r;
  logic [QW-1:0]       quo_r;
  logic [SW:0]         rem_r;
  logic                ovf_r;
  logic [SW:0]         rem_sh;
  result_t             out_r;
  logic                ov_r;
  logic signed [31:0]  offv;

  // magnitude of the current axis offset and its square
  always_comb begin
    amag  = d_r[ax_r][CW] ? (CW+1)'(-d_r[ax_r]) : d_r[ax_r];
    sq    = SW'(amag) * SW'(amag);
    if (CW + 1 > 32 && |(amag >> 32)) sq = '1;
    sadd  = {1'b0, sum_r} + {1'b0, sq};
    trial = res_r + bit_r;
    rem_sh = {rem_r[SW-1:0], num_r[NW-1]};
  end

  // classification on r = res_r
  logic signed [33:0] rr, ri, ro, cc, di, dou;
  logic               ins, hit, side;
  logic signed [33:0] cdist, wall, dlt;
  always_comb begin
    rr  = (|res_r[SW-1:32]) ? 34'sh0_ffff_ffff : 34'(res_r[31:0]);
    ri  = 34'(rin_r);
    ro  = 34'(rout_r);
    cc  = 34'(cutoff);
    ins = (rr <= ro) && (rr >= ri);
    hit = 1'b0; side = 1'b0; cdist = '0; wall = '0; dlt = '0;
    di  = ri - rr;
    dou = rr - ro;
    if (rr > 0) begin
      if (interior) begin
        if (ins) begin
          if (rr - ri < cc) begin
            hit = 1'b1; cdist = rr - ri; wall = ri; dlt = rr - ri;
          end else if (ro - rr < cc) begin
            hit = 1'b1; side = 1'b1; cdist = ro - rr; wall = -ro; dlt = rr - ro;
          end
        end
      end else if (!(rr < ro && rr > ri)) begin
        if (di > 0 && di < cc) begin
          hit = 1'b1; cdist = di; wall = -ri; dlt = rr - ri;
        end else if (dou > 0 && dou < cc) begin
          hit = 1'b1; side = 1'b1; cdist = dou; wall = ro; dlt = rr - ro;
        end
      end
    end
  end

  // sign and clamp of a finished quotient
  logic [QW-1:0] mag;
  always_comb begin
    mag  = ovf_r ? '1 : quo_r;
    if (mag > QW'(32'h7fffffff)) mag = QW'(32'h7fffffff);
    offv = ((d_r[ax_r][CW] != dneg_r) && mag != '0) ? -32'(mag) : 32'(mag);
  end

  assign q_pop     = (st_r == S_IDLE) && q_valid && !ov_r;
  assign res_valid = ov_r;
  assign res       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ov_r  <= 1'b0;
      cnt_r <= '0;
      ax_r  <= '0;
    end else begin
      if (ov_r && res_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_pop) begin
          out_r <= '0;
          if (q_tick == OP_TICK) begin
            ov_r <= 1'b1;
          end else begin
            st_r   <= S_SQ;
            ax_r   <= 2'd0;
            sum_r  <= '0;
            d_r    <= '{q_dx, q_dy, q_dz};
            rin_r  <= q_rin;
            rout_r <= q_rout;
          end
        end
        S_SQ: begin
          sum_r <= sadd[SW] ? '1 : sadd[SW-1:0];
          if (ax_r == 2'd2) begin
            st_r  <= S_ROOT;
            cnt_r <= '0;
            res_r <= '0;
            v_r   <= sadd[SW] ? '1 : sadd[SW-1:0];
            bit_r <= SW'(1) << (SW - 2);
          end else begin
            ax_r <= ax_r + 1'b1;
          end
        end
        S_ROOT: begin
          if (v_r >= trial) begin
            v_r   <= v_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'd31) st_r <= S_CLS;
        end
        S_CLS: begin
          out_r.in_shell <= ins;
          if (hit) begin
            out_r.has_contact      <= 1'b1;
            out_r.contact_distance <= cdist[RAD_W-1:0];
            out_r.wall_radius      <= wall[31:0];
            out_r.wall_side        <= side;
            dneg_r  <= dlt[33];
            delta_r <= dlt[33] ? 32'(-dlt) : dlt[31:0];
            ax_r    <= 2'd0;
            st_r    <= S_MUL;
          end else begin
            ov_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        S_MUL: begin
          num_r <= NW'(amag) * NW'(delta_r);
          quo_r <= '0;
          rem_r <= '0;
          ovf_r <= 1'b0;
          cnt_r <= '0;
          st_r  <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one dividend bit per cycle
          num_r <= num_r << 1;
          if (quo_r[QW-1]) ovf_r <= 1'b1;
          if (rem_sh >= {1'b0, res_r}) begin
            rem_r <= rem_sh - {1'b0, res_r};
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'd127) st_r <= S_OUT;
        end
        S_OUT: begin
          case (ax_r)
            2'd0: out_r.offset_x <= offv;
            2'd1: out_r.offset_y <= offv;
            default: out_r.offset_z <= offv;
          endcase
          if (ax_r == 2'd2) begin
            ov_r <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            ax_r <= ax_r + 1'b1;
            st_r <= S_MUL;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !res_ready) |=> ov_r && $stable(out_r)) else $error("result lost");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !q_pop) else $error("pop while busy");
  a_contact_r: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLS && hit) |-> res_r != '0) else $error("contact at center");
endmodule

// ----- hw/rtl/spherical_shell_wall_contact_core.sv -----
// ----------------------------------------------------------------------------
// spherical_shell_wall_contact_core: shell wall contact engine
// Point queries against a growing spherical shell, plus time ticks.
// ----------------------------------------------------------------------------
// Usage: write registers through cfg_we/cfg_index/cfg_wdata while idle, then
// send items on the in_ channel (op 0 point, op 1 tick). Each item yields one
// result on the out_ channel, in order.
// A front stage takes items into a two-entry queue; ticks update the growth
// and step count there at once. The back engine runs one point at a time:
// squares, a square root (one bit per cycle), a classify step, and for a
// contact a multiply and serial divide by r for each of the three axes. A
// tick is passed on as an all-zero result.
// Reset clears registers to their reset values, growth and step count.
// When out_ready is low the result holds; the queue keeps accepting until
// both entries are full.
// ----------------------------------------------------------------------------
module spherical_shell_wall_contact_core import sswc_pkg::*; #(
  parameter int unsigned COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int unsigned GROW_START_STEP = GROW_START_STEP_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [COORD_WIDTH-1:0] in_point_x,
  input  logic [COORD_WIDTH-1:0] in_point_y,
  input  logic [COORD_WIDTH-1:0] in_point_z,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);
  logic signed [COORD_WIDTH-1:0] cx_r, cy_r, cz_r;
  logic [RAD_W-1:0]  outer_r, thick_r, cut_r;
  logic signed [31:0] grow_r;
  logic              int_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; cz_r <= '0;
      outer_r <= '0; thick_r <= '0; cut_r <= '0; grow_r <= '0;
      int_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: cx_r    <= COORD_WIDTH'(signed'(cfg_wdata));
        REG_CENTER_Y: cy_r    <= COORD_WIDTH'(signed'(cfg_wdata));
        REG_CENTER_Z: cz_r    <= COORD_WIDTH'(signed'(cfg_wdata));
        REG_OUTER:    outer_r <= cfg_wdata[RAD_W-1:0];
        REG_THICK:    thick_r <= cfg_wdata[RAD_W-1:0];
        REG_CUTOFF:   cut_r   <= cfg_wdata[RAD_W-1:0];
        REG_GROWTH:   grow_r  <= cfg_wdata;
        REG_INTERIOR: int_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic                          q_valid, q_pop, q_tick;
  logic signed [COORD_WIDTH:0]   q_dx, q_dy, q_dz;
  logic [RAD_W-1:0]              q_rin, q_rout;

  sswc_front #(.CW(COORD_WIDTH), .GSS(GROW_START_STEP)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op,
    .in_x(signed'(in_point_x)), .in_y(signed'(in_point_y)),
    .in_z(signed'(in_point_z)),
    .cx(cx_r), .cy(cy_r), .cz(cz_r), .outer(outer_r), .thick(thick_r),
    .growth(grow_r), .q_valid, .q_pop, .q_tick, .q_dx, .q_dy, .q_dz,
    .q_rin, .q_rout
  );

  sswc_back #(.CW(COORD_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_tick, .q_dx, .q_dy, .q_dz,
    .q_rin, .q_rout, .cutoff(cut_r), .interior(int_r),
    .res_valid(out_valid), .res_ready(out_ready), .res(out_data)
  );
endmodule

// ----- verif/tb_spherical_shell_wall_contact_core.sv -----
// ----------------------------------------------------------------------------
// tb_spherical_shell_wall_contact_core: shell wall contact testbench
// Drives point queries and ticks under several register settings, predicts most
// results with a model of radius, shell test, contact and offset math (the rest
// are fixed), and checks each result field by field with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_spherical_shell_wall_contact_core import sswc_pkg::*;;

  typedef struct packed {
    logic        op;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } point_t;

  localparam longint MAX31 = 64'sd2147483647;
  localparam int unsigned GROW_START = GROW_START_STEP_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_ITEMS = 105;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  sswc_if #(.T(point_t))  in_ch ();
  sswc_if #(.T(result_t)) out_ch ();

  spherical_shell_wall_contact_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_op      (in_ch.data.op),
    .in_point_x (in_ch.data.px),
    .in_point_y (in_ch.data.py),
    .in_point_z (in_ch.data.pz),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // model copy of registers and state
  logic signed [31:0] m_cx, m_cy, m_cz, m_growth;
  logic [30:0]        m_outer, m_thick, m_cutoff;
  logic               m_interior;
  longint             m_growth_offset;
  int unsigned        m_steps;

  result_t pending_results[$];
  int      error_count;
  int      idle_cycles;
  int      stall_left;

  always #1 clk = ~clk;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic longint clamp_radius(input longint v);
    if (v < 0) return 0;
    if (v > MAX31) return MAX31;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input logic [63:0] v);
    logic [63:0] acc;
    logic [63:0] bitv;
    acc  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= acc + bitv) begin
        v   = v - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  function automatic logic [31:0] wall_offset(input longint d, input longint delta,
                                              input longint unsigned r);
    logic [127:0] prod;
    logic [127:0] q;
    longint unsigned ad, ae, mag;
    ad   = (d < 0) ? -d : d;
    ae   = (delta < 0) ? -delta : delta;
    prod = {64'b0, ad} * {64'b0, ae};
    q    = prod / {64'b0, r};
    mag  = (q > 128'(MAX31)) ? MAX31 : q[63:0];
    if (((d < 0) != (delta < 0)) && mag != 0) mag = -mag;
    return mag[31:0];
  endfunction

  function automatic longint outer_now();
    return clamp_radius(longint'(m_outer) + m_growth_offset);
  endfunction

  function automatic longint inner_now();
    return clamp_radius(longint'(m_outer) - longint'(m_thick) + m_growth_offset);
  endfunction

  // advance state for a tick, or classify a point against the shell
  function automatic result_t shell_contact(input point_t p);
    result_t res;
    longint dx, dy, dz, r, rout, rin, cut, cdist, delta, wall, di, dout;
    longint unsigned ax, ay, az;
    logic [65:0] sum;
    logic hit, side, in_sh;
    res = '0;
    if (p.op == OP_TICK) begin
      if (m_steps < GROW_START + 1) m_steps++;
      if (m_steps > GROW_START) begin
        m_growth_offset = m_growth_offset + longint'(m_growth);
        if (m_growth_offset > MAX31) m_growth_offset = MAX31;
        if (m_growth_offset < -MAX31 - 1) m_growth_offset = -MAX31 - 1;
      end
      return res;
    end
    dx  = longint'($signed(p.px)) - longint'(m_cx);
    dy  = longint'($signed(p.py)) - longint'(m_cy);
    dz  = longint'($signed(p.pz)) - longint'(m_cz);
    ax  = (dx < 0) ? -dx : dx;
    ay  = (dy < 0) ? -dy : dy;
    az  = (dz < 0) ? -dz : dz;
    sum = 66'(ax * ax) + 66'(ay * ay) + 66'(az * az);
    if (sum[65:64] != 0) sum = {2'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    r     = int_sqrt(sum[63:0]);
    rout  = outer_now();
    rin   = inner_now();
    cut   = longint'(m_cutoff);
    in_sh = (r <= rout) && (r >= rin);
    hit = 0; side = 0; cdist = 0; delta = 0; wall = 0;
    if (r > 0) begin
      if (m_interior) begin
        if (in_sh) begin
          if (r - rin < cut) begin
            hit = 1; side = 0; cdist = r - rin; wall = rin; delta = r - rin;
          end else if (rout - r < cut) begin
            hit = 1; side = 1; cdist = rout - r; wall = -rout; delta = r - rout;
          end
        end
      end else if (!(r < rout && r > rin)) begin
        di   = rin - r;
        dout = r - rout;
        if (di > 0 && di < cut) begin
          hit = 1; side = 0; cdist = di; wall = -rin; delta = r - rin;
        end else if (dout > 0 && dout < cut) begin
          hit = 1; side = 1; cdist = dout; wall = rout; delta = r - rout;
        end
      end
    end
    res.in_shell = in_sh;
    if (hit) begin
      res.has_contact      = 1'b1;
      res.contact_distance = cdist[30:0];
      res.offset_x         = wall_offset(dx, delta, r);
      res.offset_y         = wall_offset(dy, delta, r);
      res.offset_z         = wall_offset(dz, delta, r);
      res.wall_radius      = wall[31:0];
      res.wall_side        = side;
    end
    return res;
  endfunction

  task automatic compare_result(input result_t got, input result_t want);
    if (got.in_shell !== want.in_shell)
      report($sformatf("in_shell %0b, want %0b", got.in_shell, want.in_shell));
    if (got.has_contact !== want.has_contact)
      report($sformatf("has_contact %0b, want %0b", got.has_contact, want.has_contact));
    if (got.contact_distance !== want.contact_distance)
      report($sformatf("contact_distance %h, want %h",
                       got.contact_distance, want.contact_distance));
    if (got.offset_x !== want.offset_x)
      report($sformatf("offset_x %h, want %h", got.offset_x, want.offset_x));
    if (got.offset_y !== want.offset_y)
      report($sformatf("offset_y %h, want %h", got.offset_y, want.offset_y));
    if (got.offset_z !== want.offset_z)
      report($sformatf("offset_z %h, want %h", got.offset_z, want.offset_z));
    if (got.wall_radius !== want.wall_radius)
      report($sformatf("wall_radius %h, want %h", got.wall_radius, want.wall_radius));
    if (got.wall_side !== want.wall_side)
      report($sformatf("wall_side %0b, want %0b", got.wall_side, want.wall_side));
  endtask

  // result side: random stalls, checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          if (pending_results.size() == 0)
            report("result with nothing expected");
          else
            compare_result(out_ch.data, pending_results.pop_front());
        end
        if (stall_left > 0) begin
          stall_left     <= stall_left - 1;
          out_ch.ready   <= 1'b0;
        end else if ($urandom_range(0, 99) < 12) begin
          stall_left     <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                         : $urandom_range(1, 4);
          out_ch.ready   <= 1'b0;
        end else begin
          out_ch.ready   <= 1'b1;
        end
      end
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // hold valid until accepted; drop it only when a gap or a drain follows
  task automatic send_item(input point_t p, input int gap, input bit known,
                           input result_t known_res);
    result_t want;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= p;
    do @(posedge clk); while (!in_ch.ready);
    want = shell_contact(p);
    pending_results.push_back(known ? known_res : want);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
      case (IDX_W'(i))
        REG_CENTER_X: m_cx       = v[i];
        REG_CENTER_Y: m_cy       = v[i];
        REG_CENTER_Z: m_cz       = v[i];
        REG_OUTER:    m_outer    = v[i][30:0];
        REG_THICK:    m_thick    = v[i][30:0];
        REG_CUTOFF:   m_cutoff   = v[i][30:0];
        REG_GROWTH:   m_growth   = v[i];
        REG_INTERIOR: m_interior = v[i][0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic point_t mk(input logic op, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] z);
    point_t p;
    p.op = op; p.px = x; p.py = y; p.pz = z;
    return p;
  endfunction

  // mostly points close to a wall, some anywhere in the cube, some ticks
  function automatic point_t gen_item();
    longint t, ox, oy, oz, wall, span;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) return mk(OP_TICK, $urandom, $urandom, $urandom);
    if (sel < 25) return mk(OP_POINT, $urandom, $urandom, $urandom);
    wall = ($urandom_range(0, 1) == 1) ? outer_now() : inner_now();
    span = longint'(m_cutoff) * 2 + 4;
    if (span > 64'sd1 << 30) span = 64'sd1 << 30;
    t = wall + longint'($urandom) % span - span / 2;
    if (t < 0) t = 0;
    if (t > MAX31) t = MAX31;
    if (sel < 60) begin
      ox = t; oy = 0; oz = 0;
      case ($urandom_range(0, 2))
        0: begin ox = t; end
        1: begin ox = 0; oy = t; end
        default: begin ox = 0; oz = t; end
      endcase
    end else begin
      ox = (t == 0) ? 0 : longint'($urandom) % (t / 2 + 1);
      oy = (t == 0) ? 0 : longint'($urandom) % (t / 2 + 1);
      oz = int_sqrt(64'(t * t - ox * ox - oy * oy));
    end
    if ($urandom_range(0, 1)) ox = -ox;
    if ($urandom_range(0, 1)) oy = -oy;
    if ($urandom_range(0, 1)) oz = -oz;
    return mk(OP_POINT, 32'(longint'(m_cx) + ox), 32'(longint'(m_cy) + oy),
              32'(longint'(m_cz) + oz));
  endfunction

  point_t       dir_items[$];
  bit           dir_known[$];
  result_t      dir_results[$];
  logic [31:0]  phase_regs[NUM_PHASES][8];
  logic [31:0]  dir_regs[8];

  initial begin
    result_t zero_res, at_center;
    point_t  p;

    clk = 1'b0; rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    out_ch.ready = 1'b0;
    error_count = 0; idle_cycles = 0; stall_left = 0;
    m_cx = 0; m_cy = 0; m_cz = 0; m_outer = 0; m_thick = 0; m_cutoff = 0;
    m_growth = 0; m_interior = 1'b1; m_growth_offset = 0; m_steps = 0;

    zero_res  = '0;
    at_center = '0;
    at_center.in_shell = 1'b1;

    // reset settings: zero radii, so only the center lies in the shell
    dir_items = '{mk(OP_POINT, 0, 0, 0), mk(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0),
                  mk(OP_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                  mk(OP_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                  mk(OP_POINT, 32'h0001_0000, 0, 0)};
    dir_known   = '{1, 1, 1, 1, 1};
    dir_results = '{at_center, zero_res, zero_res, zero_res, zero_res};

    dir_regs = '{0, 0, 0, 32'h000A_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 1};

    phase_regs[0] = '{32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h000A_0000,
                      32'h0003_0000, 32'h0001_0000, 32'h0000_1000, 1};
    phase_regs[1] = '{32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h000A_0000,
                      32'h0003_0000, 32'h0002_0000, 32'hFFFF_E000, 0};
    phase_regs[2] = '{32'h0123_4567, 32'hFEDC_BA98, 32'h0010_0000, 32'h03E8_0000,
                      32'h00C8_0000, 32'h0032_0000, 32'h0003_0000, 0};
    phase_regs[3] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 1};
    phase_regs[4] = '{0, 0, 0, 32'h0005_0000, 32'h0009_0000, 32'h0003_0000,
                      32'hFFFF_8000, 0};
    phase_regs[5] = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 1};
    phase_regs[6] = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_0000, 32'h7FFF_FFFF,
                      32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_items[i])
      send_item(dir_items[i], pick_gap(), dir_known[i], dir_results[i]);
    drain();

    // small centered shell: walls at 7.0 and 10.0, cutoff 1.0
    write_regs(dir_regs);
    dir_items = '{mk(OP_POINT, 32'h0007_8000, 0, 0), mk(OP_POINT, 0, 32'hFFF6_8000, 0),
                  mk(OP_POINT, 0, 0, 32'h0008_8000), mk(OP_POINT, 32'h0007_0000, 0, 0),
                  mk(OP_POINT, 32'h000A_0000, 0, 0), mk(OP_POINT, 0, 0, 0),
                  mk(OP_POINT, 32'h0005_0000, 32'h0005_0000, 32'h0004_0000),
                  mk(OP_POINT, 32'h0004_0000, 32'hFFFC_0000, 32'hFFFA_0000),
                  mk(OP_POINT, 32'h000A_8000, 0, 0), mk(OP_TICK, 0, 0, 0),
                  mk(OP_POINT, 32'h0006_0000, 0, 0), mk(OP_POINT, 0, 32'h0001, 0)};
    foreach (dir_items[i])
      send_item(dir_items[i], pick_gap(), 1'b0, zero_res);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_regs(phase_regs[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // quiet stretch in the middle of phase 2
        if (n == PHASE_ITEMS / 2 && ph == 2) drain();
        p = gen_item();
        send_item(p, (ph == 1) ? 0 : pick_gap(), 1'b0, zero_res);
      end
    end

    drain();
    repeat (500) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sswc_pkg.sv
hw/rtl/sswc_if.sv
hw/rtl/sswc_front.sv
hw/rtl/sswc_back.sv
hw/rtl/spherical_shell_wall_contact_core.sv
verif/tb_spherical_shell_wall_contact_core.sv
